/* sv/double_ended_queue_with_index_read_defines.svh */
// Assertion macros used by the queue RTL file.
`ifndef DOUBLE_ENDED_QUEUE_WITH_INDEX_READ_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_INDEX_READ_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/deq_pkg.sv */
package deq_pkg;

  localparam int CMD_W     = 3;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 10;
  localparam int CNT_OUT_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4
  } cmd_e;

endpackage

/* sv/double_ended_queue_with_index_read.sv */
// Double-ended queue of signed 32-bit values in a circular RAM of DEPTH entries,
// with push/pop at both ends and read by position from the front. One command
// is accepted per cycle while no result is held back by out_ready_i; its result
// (ok, value, count after the command) is registered and offered in the cycle
// after acceptance, and a new command is taken in the same cycle the pending
// result is taken. Pop and read values come from the synchronous read port of
// the RAM. RAM contents are undefined after reset; there is no clearing pass,
// and only entries inside the count are ever read.
`include "double_ended_queue_with_index_read_defines.svh"

module double_ended_queue_with_index_read
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [CMD_W-1:0]            command_i,
  input  logic signed [DATA_W-1:0]    data_in_i,
  input  logic [POS_W-1:0]            position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic signed [DATA_W-1:0]    data_out_o,
  output logic [CNT_OUT_W-1:0]        count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          ok_q, ok_d;
  logic          rd_sel_q, rd_sel_d;

  logic          accept;
  logic          full, empty, pos_hit;
  logic [AW-1:0] front_inc, front_dec;
  logic [AW-1:0] off;
  logic [SW-1:0] sum;
  logic [AW-1:0] slot;

  logic          op_ok, op_wr, op_rd;
  logic [AW-1:0] op_front, op_addr;
  logic [CW-1:0] op_cnt;

  logic              wr_en, rd_en;
  logic [DATA_W-1:0] rd_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign pos_hit = (PW'(position_i) < PW'(cnt_q));

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  always_comb begin
    case (cmd_e'(command_i))
      CMD_PUSH_BACK: off = AW'(cnt_q);
      CMD_POP_BACK:  off = AW'(cnt_q - CW'(1));
      CMD_READ:      off = AW'(position_i);
      default:       off = '0;
    endcase
  end

  assign sum  = SW'(front_q) + SW'(off);
  assign slot = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);

  always_comb begin
    op_ok    = 1'b0;
    op_wr    = 1'b0;
    op_rd    = 1'b0;
    op_front = front_q;
    op_cnt   = cnt_q;
    op_addr  = slot;
    case (cmd_e'(command_i))
      CMD_PUSH_BACK: begin
        if (!full) begin
          op_ok  = 1'b1;
          op_wr  = 1'b1;
          op_cnt = cnt_q + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        op_addr = front_dec;
        if (!full) begin
          op_ok    = 1'b1;
          op_wr    = 1'b1;
          op_front = front_dec;
          op_cnt   = cnt_q + CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (!empty) begin
          op_ok  = 1'b1;
          op_rd  = 1'b1;
          op_cnt = cnt_q - CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        op_addr = front_q;
        if (!empty) begin
          op_ok    = 1'b1;
          op_rd    = 1'b1;
          op_front = front_inc;
          op_cnt   = cnt_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (pos_hit) begin
          op_ok = 1'b1;
          op_rd = 1'b1;
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign wr_en = accept && op_wr;
  assign rd_en = accept && op_rd;

  always_comb begin
    front_d     = front_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      front_d     = op_front;
      cnt_d       = op_cnt;
      ok_d        = op_ok;
      rd_sel_d    = op_rd;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      ok_q        <= ok_d;
      rd_sel_q    <= rd_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  deq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (op_addr),
    .wr_data_i (data_in_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (op_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = rd_sel_q ? rd_data : '0;
  assign count_o     = CNT_OUT_W'(cnt_q);

  `DEQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "count above depth")
  `DEQ_ASSERT(a_front_bound, clk_i, rst_ni, front_q <= AW'(DEPTH - 1), "front pointer out of range")
  `DEQ_ASSERT(a_push_inc, clk_i, rst_ni, accept && op_wr |=> cnt_q == $past(cnt_q) + CW'(1), "push did not advance count")
  `DEQ_ASSERT(a_empty_pop, clk_i, rst_ni, accept && empty && (command_i == CMD_POP_BACK || command_i == CMD_POP_FRONT) |=> !ok_q && cnt_q == '0, "pop on empty reported success")
  `DEQ_ASSERT(a_rd_ok, clk_i, rst_ni, rd_sel_q |-> ok_q, "RAM data selected for a failed command")

endmodule

/* sv/deq_mem.sv */
module deq_mem
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
